// ----- rtl/swsed_pkg.sv -----
// Package for the split window step edge detector.
// Holds window geometry, field widths and the controller/datapath types.
// No dependencies.
`timescale 1ns / 1ps

package swsed_pkg;

    localparam int WINDOW_LEN = 16;
    localparam int SPLIT_POS  = 8;

    // clamp split so that both parts hold at least one sample
    localparam int OLD_LEN = (SPLIT_POS < 1) ? 1 :
                             ((SPLIT_POS >= WINDOW_LEN) ? WINDOW_LEN - 1 : SPLIT_POS);
    localparam int NEW_LEN = WINDOW_LEN - OLD_LEN;

    localparam int SAMPLE_W = 24;
    localparam int THRESH_W = 24;
    localparam int VEL_W    = 25;
    localparam int IDX_W    = $clog2(WINDOW_LEN);
    localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LEN);

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MEAN,
        ST_VEL,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic write;
        logic scan;
        logic calc_mean;
        logic calc_vel;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic fill_now;
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/swsed_if.sv -----
// Valid/ready channel interfaces for sample words and result words.
// Depends on swsed_pkg for field widths.
`timescale 1ns / 1ps

interface swsed_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [swsed_pkg::SAMPLE_W-1:0]     sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swsed_out_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      window_ready;
    logic                                      edge_found;
    logic signed [swsed_pkg::VEL_W-1:0]        velocity;
    logic signed [swsed_pkg::SAMPLE_W-1:0]     split_sample;

    modport source (output valid, output window_ready, output edge_found,
                    output velocity, output split_sample, input ready);
    modport sink   (input valid, input window_ready, input edge_found,
                    input velocity, input split_sample, output ready);
endinterface

// ----- rtl/swsed_ctrl.sv -----
// Sequencer: accept, scan, mean, velocity, result; no scan while filling.
// Depends on swsed_pkg; drives commands into swsed_dp.
`timescale 1ns / 1ps

module swsed_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  swsed_pkg::t_dp_status i_status,
    output swsed_pkg::t_ctrl_cmd  o_cmd
);
    import swsed_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.fill_now ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN:   n_state = ST_VEL;
            ST_VEL:    n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.write = i_in_valid;
            end
            ST_SCAN:   o_cmd.scan      = 1'b1;
            ST_MEAN:   o_cmd.calc_mean = 1'b1;
            ST_VEL:    o_cmd.calc_vel  = 1'b1;
            ST_RESULT: o_cmd.load_out  = i_status.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/swsed_dp.sv -----
// Datapath: sample ring memory, scan accumulators, means, velocity, edge test,
// threshold register and output word register. Depends on swsed_pkg.
`timescale 1ns / 1ps

module swsed_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [swsed_pkg::THRESH_W-1:0]        i_cfg_wr_data,
    input  logic signed [swsed_pkg::SAMPLE_W-1:0] i_sample,
    input  swsed_pkg::t_ctrl_cmd                  i_cmd,
    output swsed_pkg::t_dp_status                 o_status,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_window_ready,
    output logic                                  o_edge_found,
    output logic signed [swsed_pkg::VEL_W-1:0]    o_velocity,
    output logic signed [swsed_pkg::SAMPLE_W-1:0] o_split_sample
);
    import swsed_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [WINDOW_LEN];

    logic [THRESH_W-1:0]        r_edge_threshold;
    logic [IDX_W-1:0]           r_wr_pos;
    logic [IDX_W-1:0]           n_wr_pos;
    logic                       r_full;
    logic [IDX_W-1:0]           r_rd_ptr;
    logic [CNT_W-1:0]           r_issue_cnt;
    logic                       r_rd_vld;
    logic [IDX_W-1:0]           r_rd_idx;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       issue;
    logic                       wr_wrap;

    logic signed [SUM_W-1:0]    r_sum_old;
    logic signed [SUM_W-1:0]    r_sum_new;
    logic signed [SAMPLE_W-1:0] r_old_min;
    logic signed [SAMPLE_W-1:0] r_old_max;
    logic signed [SAMPLE_W-1:0] r_new_min;
    logic signed [SAMPLE_W-1:0] r_new_max;
    logic signed [SAMPLE_W-1:0] r_split;
    logic signed [SUM_W-1:0]    rd_ext;

    logic signed [SAMPLE_W-1:0] r_mean_old;
    logic signed [SAMPLE_W-1:0] r_mean_new;
    logic signed [VEL_W-1:0]    diff;
    logic [VEL_W-1:0]           mag;
    logic                       apart;
    logic signed [VEL_W-1:0]    r_vel;
    logic                       r_edge;

    logic                       r_out_valid;
    logic                       r_out_window_ready;
    logic                       r_out_edge;
    logic signed [VEL_W-1:0]    r_out_vel;
    logic signed [SAMPLE_W-1:0] r_out_split;

    assign wr_wrap  = (r_wr_pos == IDX_W'(WINDOW_LEN - 1));
    assign n_wr_pos = wr_wrap ? '0 : r_wr_pos + 1'b1;
    assign issue    = i_cmd.scan && (r_issue_cnt != CNT_W'(WINDOW_LEN));

    assign o_status.fill_now  = r_full || wr_wrap;
    assign o_status.scan_done = r_rd_vld && (r_rd_idx == IDX_W'(WINDOW_LEN - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_threshold <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_edge_threshold <= i_cfg_wr_data;
        end
    end

    // ring memory: write on accept, registered read during scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_wr_pos] <= i_sample;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // write position, fill flag and scan address sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_full      <= 1'b0;
            r_rd_ptr    <= '0;
            r_issue_cnt <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.write) begin
                r_wr_pos    <= n_wr_pos;
                r_rd_ptr    <= n_wr_pos;  // oldest entry after this write
                r_issue_cnt <= '0;
                if (wr_wrap) begin
                    r_full <= 1'b1;
                end
            end else if (issue) begin
                r_rd_ptr    <= (r_rd_ptr == IDX_W'(WINDOW_LEN - 1)) ? '0 : r_rd_ptr + 1'b1;
                r_issue_cnt <= r_issue_cnt + 1'b1;
                r_rd_idx    <= r_issue_cnt[IDX_W-1:0];
            end
        end
    end

    assign rd_ext = SUM_W'(r_rd_data);

    // per-part sum, min and max over the scan
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_idx == '0) begin
                r_sum_old <= rd_ext;
                r_old_min <= r_rd_data;
                r_old_max <= r_rd_data;
            end else if (r_rd_idx < IDX_W'(OLD_LEN)) begin
                r_sum_old <= r_sum_old + rd_ext;
                if (r_rd_data < r_old_min) r_old_min <= r_rd_data;
                if (r_rd_data > r_old_max) r_old_max <= r_rd_data;
            end else if (r_rd_idx == IDX_W'(OLD_LEN)) begin
                r_sum_new <= rd_ext;
                r_new_min <= r_rd_data;
                r_new_max <= r_rd_data;
                r_split   <= r_rd_data;
            end else begin
                r_sum_new <= r_sum_new + rd_ext;
                if (r_rd_data < r_new_min) r_new_min <= r_rd_data;
                if (r_rd_data > r_new_max) r_new_max <= r_rd_data;
            end
        end
    end

    // part means, truncated toward zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_mean) begin
            r_mean_old <= SAMPLE_W'(r_sum_old / OLD_LEN);
            r_mean_new <= SAMPLE_W'(r_sum_new / NEW_LEN);
        end
    end

    assign diff  = VEL_W'(r_mean_new) - VEL_W'(r_mean_old);
    assign mag   = diff[VEL_W-1] ? VEL_W'(-diff) : VEL_W'(diff);
    assign apart = (r_old_max < r_new_min) || (r_new_max < r_old_min);

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_vel) begin
            r_vel  <= VEL_W'(diff / NEW_LEN);
            r_edge <= (VEL_W'(r_edge_threshold) <= mag) && apart;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_window_ready <= r_full;
            r_out_edge         <= r_full && r_edge;
            r_out_vel          <= r_full ? r_vel : '0;
            r_out_split        <= r_full ? r_split : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_ready = r_out_window_ready;
    assign o_edge_found   = r_out_edge;
    assign o_velocity     = r_out_vel;
    assign o_split_sample = r_out_split;

endmodule

// ----- rtl/split_window_step_edge_detector_core.sv -----
// Split window step edge detector top: controller and datapath on the sample
// and result channels. Depends on swsed_pkg, swsed_if, swsed_ctrl, swsed_dp.
// Per accepted sample: scan of the window at one read per cycle, mean,
// velocity, result load (straight to result load while the window fills).
// Result load waits for a free output register, then a new sample is taken.
// Reset: sync active low; clears position, fill flag, out valid; threshold 100.
`timescale 1ns / 1ps

module split_window_step_edge_detector_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [swsed_pkg::THRESH_W-1:0]  i_cfg_wr_data,
    swsed_in_if.sink                        i_in,
    swsed_out_if.source                     o_out
);
    import swsed_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    swsed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swsed_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample       (i_in.sample),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_window_ready (o_out.window_ready),
        .o_edge_found   (o_out.edge_found),
        .o_velocity     (o_out.velocity),
        .o_split_sample (o_out.split_sample)
    );

endmodule
